// ----- rtl/spf_pkg.sv -----
// shared types and constants for the space packet finder
package spf_pkg;

    localparam int ID_REGS       = 4;
    localparam int ID_W          = 16;
    localparam int START_W       = 16;
    localparam int SIZE_W        = 17;
    localparam int HCNT_W        = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int ID_COUNT_W    = 3;

    localparam logic [HCNT_W-1:0] HDR_AFTER_START = 3'd1;
    localparam logic [HCNT_W-1:0] HDR_AFTER_ID    = 3'd2;
    localparam logic [HCNT_W-1:0] HDR_LEN_HI      = 3'd4;
    localparam logic [HCNT_W-1:0] HDR_LEN_LO      = 3'd5;
    localparam logic [SIZE_W-1:0] SIZE_EXTRA      = 17'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_ID_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_LAST  = 3'd4;

    typedef enum logic [1:0] {
        MODE_HUNT   = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_SKIP   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_SPLIT = 2'd1,
        ST_NONE  = 2'd2
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [START_W-1:0]   start;
        logic [SIZE_W-1:0]    size;
    } t_result;

endpackage

// ----- rtl/spf_parser.sv -----
// per-byte header hunt, length capture and body skip with config registers
module spf_parser #(
    parameter int MAX_FRAME_BYTES = 65536,
    parameter int NUM_IDS         = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_frame_last,
    input  logic                           i_cfg_we,
    input  logic [spf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_res_valid,
    output spf_pkg::t_result               o_res
);
    import spf_pkg::*;

    localparam int PW       = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
    localparam int ID_LIMIT = (NUM_IDS < ID_REGS) ? NUM_IDS : ID_REGS;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_FRAME_BYTES - 1);

    logic [ID_COUNT_W-1:0] r_id_count;
    logic [ID_W-1:0]       r_valid_id [ID_REGS];

    t_mode              r_mode, n_mode, mode_step;
    logic [PW-1:0]      r_pos, n_pos;
    logic [7:0]         r_prev, n_prev;
    logic               r_have_prev, n_have_prev;
    logic [HCNT_W-1:0]  r_hcnt, n_hcnt;
    logic [START_W-1:0] r_start, n_start;
    logic [7:0]         r_len_hi, n_len_hi;
    logic [SIZE_W-1:0]  r_skip, n_skip;
    logic [SIZE_W-1:0]  r_total, n_total;

    logic [ID_COUNT_W-1:0] id_lim;
    logic                  id_hit;
    logic [SIZE_W-1:0]     skip_dec;
    logic [SIZE_W-1:0]     len_field;
    logic                  found;

    assign id_lim    = (r_id_count > ID_COUNT_W'(ID_LIMIT)) ? ID_COUNT_W'(ID_LIMIT)
                                                            : r_id_count;
    assign skip_dec  = (r_skip != '0) ? r_skip - 1'b1 : '0;
    assign len_field = {1'b0, r_len_hi, i_data_byte};

    always_comb begin
        id_hit = 1'b0;
        for (int k = 0; k < ID_REGS; k++) begin
            if ((ID_COUNT_W'(k) < id_lim) && (r_valid_id[k] == {r_prev, i_data_byte})) begin
                id_hit = 1'b1;
            end
        end
    end

    // mode transition for this byte, before the frame end is applied
    always_comb begin
        mode_step = r_mode;
        case (r_mode)
            MODE_HUNT: begin
                if (r_id_count == '0 || (r_have_prev && id_hit)) begin
                    mode_step = MODE_HEADER;
                end
            end
            MODE_HEADER: begin
                if (r_hcnt == HDR_LEN_LO) begin
                    mode_step = MODE_SKIP;
                end
            end
            MODE_SKIP: begin
                if (skip_dec == '0) begin
                    mode_step = MODE_HUNT;
                end
            end
            default: mode_step = MODE_HUNT;
        endcase
        n_mode = i_frame_last ? MODE_HUNT : mode_step;
    end

    always_comb begin
        n_pos       = r_pos;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_hcnt      = r_hcnt;
        n_start     = r_start;
        n_len_hi    = r_len_hi;
        n_skip      = r_skip;
        n_total     = r_total;
        found       = 1'b0;
        case (r_mode)
            MODE_HUNT: begin
                if (r_id_count == '0) begin
                    n_start = START_W'(r_pos);
                    n_hcnt  = HDR_AFTER_START;
                end else if (r_have_prev && id_hit) begin
                    n_start = START_W'(r_pos) - 1'b1;
                    n_hcnt  = HDR_AFTER_ID;
                end else begin
                    n_prev      = i_data_byte;
                    n_have_prev = 1'b1;
                end
            end
            MODE_HEADER: begin
                if (r_hcnt == HDR_LEN_HI) begin
                    n_len_hi = i_data_byte;
                end else if (r_hcnt == HDR_LEN_LO) begin
                    n_total = len_field + SIZE_EXTRA;
                    n_skip  = len_field + 1'b1;
                end
                n_hcnt = r_hcnt + 1'b1;
            end
            MODE_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    found       = 1'b1;
                    n_have_prev = 1'b0;
                    n_hcnt      = '0;
                end
            end
            default: ;
        endcase

        o_res_valid = i_accept && (found || i_frame_last);
        if (found) begin
            o_res = '{status: ST_FOUND, start: r_start, size: r_total};
        end else if (mode_step == MODE_SKIP) begin
            o_res = '{status: ST_SPLIT, start: n_start, size: n_total};
        end else begin
            o_res = '{status: ST_NONE, start: '0, size: SIZE_W'(r_pos) + 1'b1};
        end

        if (i_frame_last) begin
            n_pos       = '0;
            n_prev      = '0;
            n_have_prev = 1'b0;
            n_hcnt      = '0;
            n_start     = '0;
            n_len_hi    = '0;
            n_skip      = '0;
            n_total     = '0;
        end else if (r_pos < POS_MAX) begin
            n_pos = r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_HUNT;
            r_pos       <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_hcnt      <= '0;
            r_start     <= '0;
            r_len_hi    <= '0;
            r_skip      <= '0;
            r_total     <= '0;
        end else if (i_accept) begin
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
            r_hcnt      <= n_hcnt;
            r_start     <= n_start;
            r_len_hi    <= n_len_hi;
            r_skip      <= n_skip;
            r_total     <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_count <= '0;
            for (int k = 0; k < ID_REGS; k++) begin
                r_valid_id[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ID_COUNT) begin
                r_id_count <= i_cfg_data[ID_COUNT_W-1:0];
            end else if (i_cfg_index >= CFG_ID_FIRST && i_cfg_index <= CFG_ID_LAST) begin
                r_valid_id[2'(i_cfg_index - CFG_ID_FIRST)] <= i_cfg_data[ID_W-1:0];
            end
        end
    end

    a_hunt_no_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HUNT) |-> (r_hcnt == '0))
        else $error("header count not clear while hunting");

    a_header_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HEADER) |-> (r_hcnt >= HDR_AFTER_START && r_hcnt <= HDR_LEN_LO))
        else $error("header count out of range");

    a_skip_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_SKIP) |-> (r_skip != '0))
        else $error("skip mode with nothing left to skip");

endmodule

// ----- rtl/spf_out_buf.sv -----
// output register with one skid entry for result words
module spf_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  spf_pkg::t_result i_res,
    output logic             o_in_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output spf_pkg::t_result o_res
);
    import spf_pkg::*;

    logic    r_ov, r_sv;
    t_result r_out, r_skid;
    logic    out_free;

    assign out_free   = !r_ov || i_ready;
    assign o_in_ready = !r_sv;
    assign o_valid    = r_ov;
    assign o_res      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (out_free) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= i_res_valid;
            end
        end else if (i_res_valid) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_sv ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry held with empty output register");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && !i_ready && i_res_valid))
        else $error("skid entry filled without a stalled output");

endmodule

// ----- rtl/space_packet_finder.sv -----
// top level of the space packet finder
//
//  channel  direction  handshake                  payload
//  input    in         i_valid / o_ready          i_data_byte, i_frame_last
//  result   out        o_valid / i_ready          o_status, o_packet_start, o_packet_size
//  config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one byte word per cycle while o_ready is high; the parse state updates in the
// accepting cycle and the result that a byte causes is registered for the output
// an output register plus one skid entry hold results; input stalls only
// when both are full
// synchronous active-low reset clears parse state and all id registers
// config is always ready; writes to indexes past the last id are dropped
module space_packet_finder #(
    parameter int MAX_FRAME_BYTES = 65536,
    parameter int NUM_IDS         = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_frame_last,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_status,
    output logic [spf_pkg::START_W-1:0]    o_packet_start,
    output logic [spf_pkg::SIZE_W-1:0]     o_packet_size,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [spf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import spf_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    spf_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .NUM_IDS        (NUM_IDS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_frame_last(i_frame_last),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    spf_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_valid(res_valid),
        .i_res      (res),
        .o_in_ready (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res)
    );

    assign o_status       = out_res.status;
    assign o_packet_start = out_res.start;
    assign o_packet_size  = out_res.size;

endmodule
